// ===== rtl/psag_pkg.sv =====
package psag_pkg;

  // Default width of the running source index
  localparam int INDEX_BITS_DEF = 32;

  // Register map, word index (byte address / 4)
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd0;
  localparam logic [2:0] REG_UPSCALE      = 3'd1;
  localparam logic [2:0] REG_IN_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_IN_WIDTH     = 3'd3;
  localparam logic [2:0] REG_IMAGES       = 3'd4;

  // Register limits (values are clamped to these when used)
  localparam logic [10:0] OC_MAX   = 11'd1024;
  localparam logic [3:0]  G_MAX    = 4'd8;
  localparam logic [11:0] HW_MAX   = 12'd2048;
  localparam logic [6:0]  NIMG_MAX = 7'd64;

  // Clamped geometry as seen by the counters and the index datapath
  typedef struct packed {
    logic [10:0] oc;
    logic [3:0]  g;
    logic [11:0] h;
    logic [11:0] w;
    logic [6:0]  nimg;
  } cfg_t;

  // One element with the counter snapshot taken when it was accepted
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [31:0] src_idx;
    logic [10:0] col;
    logic [10:0] row;
    logic [9:0]  och;
    logic [2:0]  sub_row;
    logic [2:0]  sub_col;
    logic [5:0]  img;
  } item_t;

endpackage

// ===== rtl/psag_cfg_regs.sv =====
module psag_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psag_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output psag_pkg::cfg_t                    cfg
);
  import psag_pkg::*;

  logic [10:0] oc_r;
  logic [3:0]  g_r;
  logic [11:0] h_r;
  logic [11:0] w_r;
  logic [6:0]  nimg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r   <= 11'd1;
      g_r    <= 4'd2;
      h_r    <= 12'd1;
      w_r    <= 12'd1;
      nimg_r <= 7'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OUT_CHANNELS: oc_r   <= pwdata[10:0];
        REG_UPSCALE:      g_r    <= pwdata[3:0];
        REG_IN_HEIGHT:    h_r    <= pwdata[11:0];
        REG_IN_WIDTH:     w_r    <= pwdata[11:0];
        REG_IMAGES:       nimg_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read back of the raw register values
  always_comb begin
    unique case (reg_idx)
      REG_OUT_CHANNELS: prdata = 32'(oc_r);
      REG_UPSCALE:      prdata = 32'(g_r);
      REG_IN_HEIGHT:    prdata = 32'(h_r);
      REG_IN_WIDTH:     prdata = 32'(w_r);
      REG_IMAGES:       prdata = 32'(nimg_r);
      default:          prdata = 32'd0;
    endcase
  end

  // Clamp to the legal range: zero acts as one, oversize acts as the maximum
  always_comb begin
    cfg.oc   = (oc_r == '0)     ? 11'd1 : ((oc_r > OC_MAX)     ? OC_MAX   : oc_r);
    cfg.g    = (g_r == '0)      ? 4'd1  : ((g_r > G_MAX)       ? G_MAX    : g_r);
    cfg.h    = (h_r == '0)      ? 12'd1 : ((h_r > HW_MAX)      ? HW_MAX   : h_r);
    cfg.w    = (w_r == '0)      ? 12'd1 : ((w_r > HW_MAX)      ? HW_MAX   : w_r);
    cfg.nimg = (nimg_r == '0)   ? 7'd1  : ((nimg_r > NIMG_MAX) ? NIMG_MAX : nimg_r);
  end

endmodule

// ===== rtl/psag_counter.sv =====
module psag_counter #(
  parameter int INDEX_BITS = psag_pkg::INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             restart,
  input  logic [31:0]      value,
  input  psag_pkg::cfg_t   cfg,
  output psag_pkg::item_t  item
);
  import psag_pkg::*;

  localparam int SRC_W = (INDEX_BITS < 32) ? INDEX_BITS : 32;

  logic [10:0]           col_r, col_nxt, col_e;
  logic [10:0]           row_r, row_nxt, row_e;
  logic [9:0]            och_r, och_nxt, och_e;
  logic [2:0]            srow_r, srow_nxt, srow_e;
  logic [2:0]            scol_r, scol_nxt, scol_e;
  logic [5:0]            img_r, img_nxt, img_e;
  logic [INDEX_BITS-1:0] lin_r, lin_nxt, lin_e;
  logic end_col, end_row, end_ch, end_sc, end_sr, end_img, last;

  // Restart zeroes the counters before this element is indexed
  assign col_e  = restart ? '0 : col_r;
  assign row_e  = restart ? '0 : row_r;
  assign och_e  = restart ? '0 : och_r;
  assign srow_e = restart ? '0 : srow_r;
  assign scol_e = restart ? '0 : scol_r;
  assign img_e  = restart ? '0 : img_r;
  assign lin_e  = restart ? '0 : lin_r;

  // Wrap flags; a counter whose successor reaches its limit wraps on its next advance
  assign end_col = (12'(col_e) + 12'd1) >= cfg.w;
  assign end_row = (12'(row_e) + 12'd1) >= cfg.h;
  assign end_ch  = (11'(och_e) + 11'd1) >= cfg.oc;
  assign end_sc  = (4'(scol_e) + 4'd1) >= cfg.g;
  assign end_sr  = (4'(srow_e) + 4'd1) >= cfg.g;
  assign end_img = (7'(img_e) + 7'd1) >= cfg.nimg;
  assign last    = end_col & end_row & end_ch & end_sc & end_sr & end_img;

  // Odometer advance: column, row, output channel, sub column, sub row, image
  always_comb begin
    col_nxt  = col_e;
    row_nxt  = row_e;
    och_nxt  = och_e;
    scol_nxt = scol_e;
    srow_nxt = srow_e;
    img_nxt  = img_e;
    lin_nxt  = last ? '0 : lin_e + {{(INDEX_BITS-1){1'b0}}, 1'b1};
    if (!end_col) begin
      col_nxt = col_e + 11'd1;
    end else begin
      col_nxt = '0;
      if (!end_row) begin
        row_nxt = row_e + 11'd1;
      end else begin
        row_nxt = '0;
        if (!end_ch) begin
          och_nxt = och_e + 10'd1;
        end else begin
          och_nxt = '0;
          if (!end_sc) begin
            scol_nxt = scol_e + 3'd1;
          end else begin
            scol_nxt = '0;
            if (!end_sr) begin
              srow_nxt = srow_e + 3'd1;
            end else begin
              srow_nxt = '0;
              img_nxt  = end_img ? '0 : img_e + 6'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      och_r  <= '0;
      srow_r <= '0;
      scol_r <= '0;
      img_r  <= '0;
      lin_r  <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      och_r  <= och_nxt;
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
      img_r  <= img_nxt;
      lin_r  <= lin_nxt;
    end
  end

  // Snapshot handed to the index datapath
  always_comb begin
    item.value   = value;
    item.last    = last;
    item.src_idx = 32'(lin_e[SRC_W-1:0]);
    item.col     = col_e;
    item.row     = row_e;
    item.och     = och_e;
    item.sub_row = srow_e;
    item.sub_col = scol_e;
    item.img     = img_e;
  end

endmodule

// ===== rtl/psag_index_pipe.sv =====
module psag_index_pipe #(
  parameter int INDEX_BITS = psag_pkg::INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  psag_pkg::item_t  in_item,
  input  psag_pkg::cfg_t   cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_src_idx,
  output logic [31:0]      out_shuf_idx,
  output logic [31:0]      out_element,
  output logic             out_last
);
  import psag_pkg::*;

  localparam int          SHUF_W    = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam logic [31:0] SHUF_MASK = 32'((64'd1 << SHUF_W) - 64'd1);

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [31:0] src_idx;
    logic [15:0] sw;
    logic [15:0] sh;
    logic [14:0] rowv;
    logic [14:0] colv;
    logic [15:0] chan;
  } s1_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [31:0] src_idx;
    logic [31:0] plane;
    logic [30:0] rowterm;
    logic [14:0] colv;
    logic [15:0] chan;
  } s2_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [31:0] src_idx;
    logic [31:0] chterm;
    logic [31:0] lowsum;
  } s3_t;

  item_t s0_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  logic  v0_r, v1_r, v2_r, v3_r, vo_r;
  logic  rdy0, rdy1, rdy2, rdy3, rdyo;
  logic [31:0] src_r, shuf_r, elem_r, shuf_nxt;
  logic        last_r;

  // Each stage loads when it is empty or its content moves on
  assign rdyo     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  // Stage 1: scaled sizes, sub-pixel row/column, channel plane number
  always_comb begin
    s1_nxt.value   = s0_r.value;
    s1_nxt.last    = s0_r.last;
    s1_nxt.src_idx = s0_r.src_idx;
    s1_nxt.sw      = 16'(cfg.w) * 16'(cfg.g);
    s1_nxt.sh      = 16'(cfg.h) * 16'(cfg.g);
    s1_nxt.rowv    = 15'(s0_r.row) * 15'(cfg.g) + 15'(s0_r.sub_row);
    s1_nxt.colv    = 15'(s0_r.col) * 15'(cfg.g) + 15'(s0_r.sub_col);
    s1_nxt.chan    = 16'(s0_r.img) * 16'(cfg.oc) + 16'(s0_r.och);
  end

  // Stage 2: plane size and row offset
  always_comb begin
    s2_nxt.value   = s1_r.value;
    s2_nxt.last    = s1_r.last;
    s2_nxt.src_idx = s1_r.src_idx;
    s2_nxt.plane   = 32'(s1_r.sh) * 32'(s1_r.sw);
    s2_nxt.rowterm = 31'(s1_r.rowv) * 31'(s1_r.sw);
    s2_nxt.colv    = s1_r.colv;
    s2_nxt.chan    = s1_r.chan;
  end

  // Stage 3: channel plane offset (low 32 bits) and in-plane offset
  always_comb begin
    s3_nxt.value   = s2_r.value;
    s3_nxt.last    = s2_r.last;
    s3_nxt.src_idx = s2_r.src_idx;
    s3_nxt.chterm  = 32'(s2_r.chan) * s2_r.plane;
    s3_nxt.lowsum  = 32'(s2_r.rowterm) + 32'(s2_r.colv);
  end

  assign shuf_nxt = (s3_r.chterm + s3_r.lowsum) & SHUF_MASK;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdyo) begin
        vo_r <= v3_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_r <= in_item;
    end
    if (rdy1 && v0_r) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
    if (rdyo && v3_r) begin
      src_r  <= s3_r.src_idx;
      shuf_r <= shuf_nxt;
      elem_r <= s3_r.value;
      last_r <= s3_r.last;
    end
  end

  assign out_valid    = vo_r;
  assign out_src_idx  = src_r;
  assign out_shuf_idx = shuf_r;
  assign out_element  = elem_r;
  assign out_last     = last_r;

endmodule

// ===== rtl/pixel_shuffle_address_gen.sv =====
// Depth-to-space (pixel shuffle) address generator. Feed one element per
// transfer in source order (image, channel, row, column, column fastest);
// each element comes back with its linear source index, its linear index
// in the shuffled tensor and its value, and tlast on the tensor's final
// element. in_tuser[0] restarts the counters at that element; after the
// final element the counters wrap to a new tensor by themselves. One
// element per clock is sustained while out_tready is high; each result
// passes a counter snapshot register, three arithmetic stages whose
// widest product is 16 by 32 bits, and the output register, and
// the input keeps accepting while a result waits as long as a stage is
// free. Registers (byte address): 0x00 out_channels, 0x04 upscale factor,
// 0x08 in_height, 0x0C in_width, 0x10 images; write them only while no
// element is in flight. Out-of-range register values are clamped on use.
module pixel_shuffle_address_gen #(
  parameter int INDEX_BITS = psag_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [psag_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  // input elements
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [31:0] value
  input  logic [0:0]                       in_tuser,   // [0] restart
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [95:0]                      out_tdata,  // [31:0] source_index,
                                                       // [63:32] shuffled_index,
                                                       // [95:64] element
  output logic                             out_tlast   // last
);
  import psag_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  in_accept;

  assign cfg_pready = 1'b1;
  assign in_accept  = in_tvalid & in_tready;

  psag_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  psag_counter #(
    .INDEX_BITS (INDEX_BITS)
  ) u_counter (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .restart (in_tuser[0]),
    .value   (in_tdata),
    .cfg     (cfg),
    .item    (item)
  );

  psag_index_pipe #(
    .INDEX_BITS (INDEX_BITS)
  ) u_index_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_item      (item),
    .cfg          (cfg),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_src_idx  (out_tdata[31:0]),
    .out_shuf_idx (out_tdata[63:32]),
    .out_element  (out_tdata[95:64]),
    .out_last     (out_tlast)
  );

endmodule

// ===== rtl/psag_checker.sv =====
module psag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With the output register empty, the input is ready
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // Source index steps by one, or restarts at zero
  a_src_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) ##1 (out_tvalid && out_tready)
    |-> (out_tdata[31:0] == $past(out_tdata[31:0]) + 32'd1) || (out_tdata[31:0] == 32'd0))
    else $error("source index skipped");

  // The transfer after a final element starts a new tensor
  a_src_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) ##1 (out_tvalid && out_tready)
    |-> out_tdata[31:0] == 32'd0)
    else $error("source index not zero after last");

endmodule

bind pixel_shuffle_address_gen psag_checker u_psag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
